>>> rtl/core/dmt_pkg.sv
package dmt_pkg;

  // Operation codes carried on the op field of an input word.
  typedef enum logic [1:0] {
    OP_ADD_CONN = 2'd0,
    OP_ADD_MODE = 2'd1,
    OP_SET_MODE = 2'd2,
    OP_READ_CUR = 2'd3
  } op_t;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned IN_DIM_W = 16;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned CONN_W   = 4;
  localparam int unsigned SLOT_W   = 3;
  localparam logic [IN_DIM_W-1:0] MAX_DIM = 16'd4096;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [RATE_W-1:0] r;
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RDWAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_start;
    logic scan_next;
    logic scan_end;
    logic rd_take;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic conn_ok;
    logic sel_valid;
    logic cnt_zero;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/core/display_mode_table_top.sv
// Display mode table. The block keeps CONNECTORS connector slots, each with a
// list of up to MODES_PER_CONNECTOR modes (width, height, refresh) and an
// optional selected mode, and answers every input word with exactly one result
// word. Add connector claims the lowest free slot and clears its list and
// selection; add mode validates and appends a mode; set mode selects the first
// listed mode whose width and height match; read current returns the selected
// mode. The block works on one word at a time. A word is captured in the input
// registers, decoded and executed in S_EXEC, and its result is parked in the
// output register from S_DONE. Read current with a mode selected passes through
// S_RDWAIT for the mode memory read. Set mode walks the connector's list
// through the single read port of the mode memory, comparing one stored mode
// per cycle, until a match or the last of up to MODES_PER_CONNECTOR entries.
// The result sits in an output register, so the next word is taken while a
// finished result still waits for out_ready; the block only stalls when a
// second result is ready before the first one has been taken. The mode
// memory needs no clearing after reset: only entries below a connector's mode
// count are ever used.
module display_mode_table_top
  import dmt_pkg::*;
#(
  parameter int unsigned CONNECTORS          = 8,
  parameter int unsigned MODES_PER_CONNECTOR = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [CONN_W-1:0]   in_connector,
  input  logic                in_name_present,
  input  logic [IN_DIM_W-1:0] in_width,
  input  logic [IN_DIM_W-1:0] in_height,
  input  logic [RATE_W-1:0]   in_refresh,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [DIM_W-1:0]    out_cur_width,
  output logic [DIM_W-1:0]    out_cur_height,
  output logic [RATE_W-1:0]   out_cur_refresh
);

  // The controller sequences each word; the datapath holds the table.
  cmd_t  cmd;
  stat_t stat;

  dmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmt_datapath #(
    .CONNECTORS          (CONNECTORS),
    .MODES_PER_CONNECTOR (MODES_PER_CONNECTOR)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_connector    (in_connector),
    .in_name_present (in_name_present),
    .in_width        (in_width),
    .in_height       (in_height),
    .in_refresh      (in_refresh),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_cur_width   (out_cur_width),
    .out_cur_height  (out_cur_height),
    .out_cur_refresh (out_cur_refresh)
  );

endmodule

>>> rtl/core/dmt_ctrl.sv
module dmt_ctrl
  import dmt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == OP_SET_MODE && stat.conn_ok && !stat.cnt_zero) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (stat.op == OP_READ_CUR && stat.conn_ok && stat.sel_valid) begin
          state_nxt = S_RDWAIT;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.scan_end = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/dmt_datapath.sv
module dmt_datapath
  import dmt_pkg::*;
#(
  parameter int unsigned CONNECTORS          = 8,
  parameter int unsigned MODES_PER_CONNECTOR = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [1:0]           in_op,
  input  logic [CONN_W-1:0]    in_connector,
  input  logic                 in_name_present,
  input  logic [IN_DIM_W-1:0]  in_width,
  input  logic [IN_DIM_W-1:0]  in_height,
  input  logic [RATE_W-1:0]    in_refresh,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [DIM_W-1:0]     out_cur_width,
  output logic [DIM_W-1:0]     out_cur_height,
  output logic [RATE_W-1:0]    out_cur_refresh
);

  localparam int unsigned CW        = (CONNECTORS > 1) ? $clog2(CONNECTORS) : 1;
  localparam int unsigned MW        = (MODES_PER_CONNECTOR > 1) ?
                                      $clog2(MODES_PER_CONNECTOR) : 1;
  localparam int unsigned CNT_W     = MW + 1;
  localparam int unsigned AW        = CW + MW;
  localparam int unsigned MEM_DEPTH = CONNECTORS << MW;
  localparam logic [CNT_W-1:0] MODES_MAX = CNT_W'(MODES_PER_CONNECTOR);

  // Captured input word.
  op_t                 op_r;
  logic [CONN_W-1:0]   conn_r;
  logic                name_r;
  logic [IN_DIM_W-1:0] w_r, h_r;
  logic [RATE_W-1:0]   rf_r;

  // Per-connector table.
  logic             in_use_r [CONNECTORS];
  logic             in_use_nxt [CONNECTORS];
  logic [CNT_W-1:0] cnt_r [CONNECTORS];
  logic [CNT_W-1:0] cnt_nxt [CONNECTORS];
  logic             selv_r [CONNECTORS];
  logic             selv_nxt [CONNECTORS];
  logic [MW-1:0]    seli_r [CONNECTORS];
  logic [MW-1:0]    seli_nxt [CONNECTORS];

  // Search counters: idx_r is the entry being read, cmp_r the one being compared.
  logic [MW-1:0] idx_r, idx_nxt;
  logic [MW-1:0] cmp_r, cmp_nxt;

  // Mode memory.
  mode_t mem [MEM_DEPTH];
  mode_t rd_data_r;

  // Pending result and output register.
  logic [1:0]        res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [DIM_W-1:0]  res_w_r, res_w_nxt, res_h_r, res_h_nxt;
  logic [RATE_W-1:0] res_rf_r, res_rf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [DIM_W-1:0]  out_w_r, out_h_r;
  logic [RATE_W-1:0] out_rf_r;

  logic [CW-1:0]    c_idx;
  logic             conn_ok;
  logic [CNT_W-1:0] cur_cnt;
  logic             mode_bad;
  logic             list_full;
  logic             scan_hit;
  logic             scan_last;
  logic             free_found;
  logic [CW-1:0]    free_idx;
  logic [MW-1:0]    rd_idx;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  mode_t            wdata;

  assign c_idx     = conn_r[CW-1:0];
  assign conn_ok   = (32'(conn_r) < CONNECTORS) && in_use_r[c_idx];
  assign cur_cnt   = cnt_r[c_idx];
  assign mode_bad  = (w_r == '0) || (h_r == '0) || (rf_r == '0) ||
                     (w_r > MAX_DIM) || (h_r > MAX_DIM);
  assign list_full = (cur_cnt >= MODES_MAX);
  assign scan_hit  = ({(IN_DIM_W-DIM_W)'(0), rd_data_r.w} == w_r) &&
                     ({(IN_DIM_W-DIM_W)'(0), rd_data_r.h} == h_r);
  assign scan_last = (CNT_W'({1'b0, cmp_r}) + CNT_W'(1)) == cur_cnt;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CONNECTORS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = CW'(i);
      end
    end
  end

  always_comb begin
    priority if (cmd.scan_start) begin
      rd_idx = '0;
    end else if (cmd.scan_next) begin
      rd_idx = idx_r;
    end else begin
      rd_idx = seli_r[c_idx];
    end
  end

  assign raddr  = {c_idx, rd_idx};
  assign waddr  = {c_idx, cur_cnt[MW-1:0]};
  assign wdata  = '{w: w_r[DIM_W-1:0], h: h_r[DIM_W-1:0], r: rf_r};
  assign mem_we = cmd.exec && (op_r == OP_ADD_MODE) && conn_ok && !mode_bad && !list_full;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_comb begin
    in_use_nxt     = in_use_r;
    cnt_nxt        = cnt_r;
    selv_nxt       = selv_r;
    seli_nxt       = seli_r;
    idx_nxt        = idx_r;
    cmp_nxt        = cmp_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_w_nxt      = res_w_r;
    res_h_nxt      = res_h_r;
    res_rf_nxt     = res_rf_r;

    if (cmd.exec) begin
      res_status_nxt = ST_OK;
      res_slot_nxt   = '0;
      res_w_nxt      = '0;
      res_h_nxt      = '0;
      res_rf_nxt     = '0;
      priority if (op_r == OP_ADD_CONN) begin
        priority if (!name_r) begin
          res_status_nxt = ST_BAD;
        end else if (free_found) begin
          in_use_nxt[free_idx] = 1'b1;
          cnt_nxt[free_idx]    = '0;
          selv_nxt[free_idx]   = 1'b0;
          seli_nxt[free_idx]   = '0;
          res_slot_nxt         = SLOT_W'(free_idx);
        end else begin
          res_status_nxt = ST_FULL;
        end
      end else if (!conn_ok) begin
        res_status_nxt = ST_BAD;
      end else if (op_r == OP_ADD_MODE) begin
        priority if (mode_bad) begin
          res_status_nxt = ST_BAD;
        end else if (list_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          cnt_nxt[c_idx] = cur_cnt + CNT_W'(1);
        end
      end else begin
        // Set mode on an empty list, or read with nothing selected.
        res_status_nxt = ST_FULL;
      end
    end

    if (cmd.scan_start) begin
      idx_nxt = MW'(1);
      cmp_nxt = '0;
    end

    if (cmd.scan_next) begin
      idx_nxt = idx_r + MW'(1);
      cmp_nxt = cmp_r + MW'(1);
    end

    if (cmd.scan_end) begin
      res_slot_nxt = '0;
      res_w_nxt    = '0;
      res_h_nxt    = '0;
      res_rf_nxt   = '0;
      if (scan_hit) begin
        res_status_nxt  = ST_OK;
        selv_nxt[c_idx] = 1'b1;
        seli_nxt[c_idx] = cmp_r;
      end else begin
        res_status_nxt = ST_FULL;
      end
    end

    if (cmd.rd_take) begin
      res_status_nxt = ST_OK;
      res_slot_nxt   = '0;
      res_w_nxt      = rd_data_r.w;
      res_h_nxt      = rd_data_r.h;
      res_rf_nxt     = rd_data_r.r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONNECTORS; i++) begin
        in_use_r[i] <= 1'b0;
        cnt_r[i]    <= '0;
        selv_r[i]   <= 1'b0;
        seli_r[i]   <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      in_use_r    <= in_use_nxt;
      cnt_r       <= cnt_nxt;
      selv_r      <= selv_nxt;
      seli_r      <= seli_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      conn_r <= in_connector;
      name_r <= in_name_present;
      w_r    <= in_width;
      h_r    <= in_height;
      rf_r   <= in_refresh;
    end
    idx_r        <= idx_nxt;
    cmp_r        <= cmp_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_w_r      <= res_w_nxt;
    res_h_r      <= res_h_nxt;
    res_rf_r     <= res_rf_nxt;
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_w_r      <= res_w_r;
      out_h_r      <= res_h_r;
      out_rf_r     <= res_rf_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.conn_ok   = conn_ok;
  assign stat.sel_valid = selv_r[c_idx];
  assign stat.cnt_zero  = (cur_cnt == '0);
  assign stat.scan_done = scan_hit || scan_last;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_cur_width   = out_w_r;
  assign out_cur_height  = out_h_r;
  assign out_cur_refresh = out_rf_r;

endmodule

>>> bench/display_mode_table_top_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the display mode table.
//
// The bench runs a shadow copy of the connector table: claim flags, mode lists,
// selection flags and indices. The input side updates it at the rising edge at
// which a request word is accepted, and pushes the reply that word should cause
// onto a queue. The output side pops that queue for every reply word the block
// hands over and compares it field by field. Both handshakes are exercised with
// random idle and stall stretches, and some calm stretches have none at all.
module display_mode_table_top_test;
  import dmt_pkg::*;

  localparam int NCONN        = 8;
  localparam int NMODES       = 16;
  localparam int RANDOM_WORDS = 950;
  // Cycles to let pass after the last reply.
  localparam int DRAIN_CYCLES = 40;

  // One request word as it is driven on the input channel.
  typedef struct packed {
    op_t                 op;
    logic [CONN_W-1:0]   conn;
    logic                name_ok;
    logic [IN_DIM_W-1:0] w;
    logic [IN_DIM_W-1:0] h;
    logic [RATE_W-1:0]   r;
  } request_t;

  // One reply word as it appears on the output channel.
  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [DIM_W-1:0]  cw;
    logic [DIM_W-1:0]  ch;
    logic [RATE_W-1:0] cr;
  } reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Every input is tied to a known value from time zero.
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [1:0]          in_op           = '0;
  logic [CONN_W-1:0]   in_connector    = '0;
  logic                in_name_present = 1'b0;
  logic [IN_DIM_W-1:0] in_width        = '0;
  logic [IN_DIM_W-1:0] in_height       = '0;
  logic [RATE_W-1:0]   in_refresh      = '0;
  logic                out_valid;
  logic                out_ready       = 1'b1;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [DIM_W-1:0]    out_cur_width;
  logic [DIM_W-1:0]    out_cur_height;
  logic [RATE_W-1:0]   out_cur_refresh;

  display_mode_table_top #(
    .CONNECTORS          (NCONN),
    .MODES_PER_CONNECTOR (NMODES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_connector    (in_connector),
    .in_name_present (in_name_present),
    .in_width        (in_width),
    .in_height       (in_height),
    .in_refresh      (in_refresh),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_cur_width   (out_cur_width),
    .out_cur_height  (out_cur_height),
    .out_cur_refresh (out_cur_refresh)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the connector table.
  logic                claimed  [NCONN];
  int                  n_modes  [NCONN];
  logic                has_sel  [NCONN];
  int                  sel_at   [NCONN];
  logic [IN_DIM_W-1:0] list_w   [NCONN][NMODES];
  logic [IN_DIM_W-1:0] list_h   [NCONN][NMODES];
  logic [RATE_W-1:0]   list_r   [NCONN][NMODES];

  request_t word_backlog[$];
  reply_t   expected_replies[$];

  int words_issued = 0;
  int words_taken  = 0;
  int replies_seen = 0;
  int err_count    = 0;
  int n_ok         = 0;
  int n_bad        = 0;
  int n_full       = 0;
  int n_claims     = 0;

  // A small pool of resolutions, so that set mode finds matches often and
  // duplicate entries in one list show that the first match wins.
  logic [IN_DIM_W-1:0] pool_w [4] = '{16'd640, 16'd1920, 16'd4096, 16'd1};
  logic [IN_DIM_W-1:0] pool_h [4] = '{16'd480, 16'd1080, 16'd4096, 16'd1};

  // Applies one accepted request to the shadow table and returns the reply
  // that the block must produce for it.
  function automatic reply_t update_shadow_table(request_t q);
    reply_t a;
    int     c;
    logic   live;
    a    = '0;
    c    = int'(q.conn);
    live = (c < NCONN) ? claimed[c] : 1'b0;
    if (q.op == OP_ADD_CONN) begin
      if (!q.name_ok) begin
        a.status = ST_BAD;
      end else begin
        // The lowest free slot is claimed; with none left the table is full.
        a.status = ST_FULL;
        for (int i = 0; i < NCONN; i++) begin
          if (!claimed[i]) begin
            claimed[i] = 1'b1;
            n_modes[i] = 0;
            has_sel[i] = 1'b0;
            sel_at[i]  = 0;
            a.status   = ST_OK;
            a.slot     = SLOT_W'(i);
            n_claims++;
            break;
          end
        end
      end
    end else if (!live) begin
      a.status = ST_BAD;
    end else if (q.op == OP_ADD_MODE) begin
      if (q.w == 0 || q.h == 0 || q.r == 0 || q.w > MAX_DIM || q.h > MAX_DIM) begin
        a.status = ST_BAD;
      end else if (n_modes[c] >= NMODES) begin
        a.status = ST_FULL;
      end else begin
        list_w[c][n_modes[c]] = q.w;
        list_h[c][n_modes[c]] = q.h;
        list_r[c][n_modes[c]] = q.r;
        n_modes[c]++;
        a.status = ST_OK;
      end
    end else if (q.op == OP_SET_MODE) begin
      // The search compares all 16 input bits, so a width that only agrees
      // in its low 13 bits is not a match. A miss keeps the old selection.
      a.status = ST_FULL;
      for (int i = 0; i < n_modes[c]; i++) begin
        if (list_w[c][i] == q.w && list_h[c][i] == q.h) begin
          has_sel[c] = 1'b1;
          sel_at[c]  = i;
          a.status   = ST_OK;
          break;
        end
      end
    end else begin
      if (!has_sel[c]) begin
        a.status = ST_FULL;
      end else begin
        a.status = ST_OK;
        a.cw     = list_w[c][sel_at[c]][DIM_W-1:0];
        a.ch     = list_h[c][sel_at[c]][DIM_W-1:0];
        a.cr     = list_r[c][sel_at[c]];
      end
    end
    return a;
  endfunction

  // Idle and stall lengths: mostly none or short, now and then long.
  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_word(op_t op, int conn, logic name_ok, int w, int h, int r);
    request_t q;
    q.op      = op;
    q.conn    = CONN_W'(conn);
    q.name_ok = name_ok;
    q.w       = IN_DIM_W'(w);
    q.h       = IN_DIM_W'(h);
    q.r       = RATE_W'(r);
    word_backlog.push_back(q);
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: reply %0d field %s: expected %0d, got %0d",
               $time, replies_seen, fname, want, got);
      err_count++;
    end
  endtask

  // Input driver. A word that has been presented but not yet taken is held
  // untouched. Otherwise the driver either idles for the gap it drew after the
  // previous word, or presents the next word from the backlog. Every branch
  // makes exactly one assignment to in_valid, so valid stays high across
  // back-to-back words without dropping within a time step.
  int in_idle = 0;
  int in_calm = 0;

  always @(negedge clk) begin : driver
    request_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && words_taken != words_issued) begin
      in_valid <= 1'b1;
    end else if (in_idle > 0) begin
      in_idle  <= in_idle - 1;
      in_valid <= 1'b0;
    end else if (word_backlog.size() > 0) begin
      q = word_backlog.pop_front();
      in_op           <= q.op;
      in_connector    <= q.conn;
      in_name_present <= q.name_ok;
      in_width        <= q.w;
      in_height       <= q.h;
      in_refresh      <= q.r;
      in_valid        <= 1'b1;
      words_issued    <= words_issued + 1;
      if (in_calm > 0) begin
        in_calm <= in_calm - 1;
        in_idle <= 0;
      end else begin
        in_idle <= draw_gap();
        if ($urandom_range(0, 39) == 0) in_calm <= $urandom_range(20, 60);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output back-pressure. Stalls of random length are dropped on out_ready,
  // with calm stretches in which the block is never held up.
  int out_stall = 0;
  int out_calm  = 0;

  always @(negedge clk) begin : backpressure
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_calm > 0) begin
        out_calm <= out_calm - 1;
      end else if ($urandom_range(0, 49) == 0) begin
        out_calm <= $urandom_range(20, 80);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= draw_gap();
      end
    end
  end

  // Monitor. At each rising edge an accepted request updates the shadow table
  // and queues its reply, and an accepted reply word is checked against the
  // oldest queued one. A reply can never belong to a request taken at the
  // same edge, since each word passes S_EXEC and S_DONE before it is answered.
  always @(posedge clk) begin : monitor
    reply_t want;
    request_t q;
    if (rst_n && in_valid && in_ready) begin
      q.op      = op_t'(in_op);
      q.conn    = in_connector;
      q.name_ok = in_name_present;
      q.w       = in_width;
      q.h       = in_height;
      q.r       = in_refresh;
      expected_replies.push_back(update_shadow_table(q));
      words_taken <= words_taken + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply word: status %0d slot %0d mode %0dx%0d@%0d",
                 $time, out_status, out_slot, out_cur_width, out_cur_height,
                 out_cur_refresh);
        err_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status",      32'(want.status), 32'(out_status));
        check_field("slot",        32'(want.slot),   32'(out_slot));
        check_field("cur_width",   32'(want.cw),     32'(out_cur_width));
        check_field("cur_height",  32'(want.ch),     32'(out_cur_height));
        check_field("cur_refresh", 32'(want.cr),     32'(out_cur_refresh));
        case (want.status)
          ST_OK:   n_ok++;
          ST_BAD:  n_bad++;
          default: n_full++;
        endcase
      end
      replies_seen++;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int   pick;
    int   conn;
    int   wv;
    int   hv;
    int   rv;
    logic name_ok;

    for (int i = 0; i < NCONN; i++) begin
      claimed[i] = 1'b0;
      n_modes[i] = 0;
      has_sel[i] = 1'b0;
      sel_at[i]  = 0;
    end

    // Directed opening. Nothing is claimed yet, so every connector is bad.
    push_word(OP_ADD_MODE, 0, 1'b1, 640, 480, 60);
    push_word(OP_READ_CUR, 0, 1'b1, 0, 0, 0);
    push_word(OP_SET_MODE, 0, 1'b1, 640, 480, 0);
    // A claim without a name is refused; the next one takes slot zero.
    push_word(OP_ADD_CONN, 15, 1'b0, 0, 0, 0);
    push_word(OP_ADD_CONN, 15, 1'b1, 65535, 65535, 65535);
    // A fresh connector has no selection and an empty list.
    push_word(OP_READ_CUR, 0, 1'b1, 0, 0, 0);
    push_word(OP_SET_MODE, 0, 1'b1, 640, 480, 0);
    // Malformed modes: each zero field and each dimension past 4096.
    push_word(OP_ADD_MODE, 0, 1'b0, 0, 480, 60);
    push_word(OP_ADD_MODE, 0, 1'b0, 640, 0, 60);
    push_word(OP_ADD_MODE, 0, 1'b0, 640, 480, 0);
    push_word(OP_ADD_MODE, 0, 1'b0, 65535, 480, 60);
    push_word(OP_ADD_MODE, 0, 1'b0, 640, 4097, 60);
    // Largest and smallest legal modes.
    push_word(OP_ADD_MODE, 0, 1'b0, 4096, 4096, 65535);
    push_word(OP_ADD_MODE, 0, 1'b0, 1, 1, 1);
    // A width whose low 13 bits equal 4096 must not match 4096.
    push_word(OP_SET_MODE, 0, 1'b0, 4096 + 8192, 4096, 0);
    push_word(OP_READ_CUR, 0, 1'b0, 0, 0, 0);
    push_word(OP_SET_MODE, 0, 1'b0, 4096, 4096, 0);
    push_word(OP_READ_CUR, 0, 1'b0, 0, 0, 0);
    // A miss after a hit keeps the earlier selection.
    push_word(OP_SET_MODE, 0, 1'b0, 1, 4096, 0);
    push_word(OP_READ_CUR, 0, 1'b0, 65535, 65535, 65535);
    // Out-of-range and unclaimed connectors.
    push_word(OP_ADD_MODE, 15, 1'b1, 640, 480, 60);
    push_word(OP_SET_MODE, 8, 1'b1, 4096, 4096, 0);
    push_word(OP_READ_CUR, 1, 1'b1, 0, 0, 0);

    // Random part. Claims come often early on so that all slots fill and the
    // full table is hit later. Most mode traffic draws from the resolution
    // pool so lists fill up and set mode finds matches; the rest is noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick    = $urandom_range(0, 99);
      conn    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15)
                                            : $urandom_range(0, NCONN - 1);
      name_ok = ($urandom_range(0, 9) != 0);
      wv      = int'(pool_w[$urandom_range(0, 3)]);
      hv      = int'(pool_h[$urandom_range(0, 3)]);
      rv      = $urandom_range(1, 65535);
      if (pick < ((n < 120) ? 12 : 3)) begin
        push_word(OP_ADD_CONN, conn, name_ok, $urandom, $urandom, $urandom);
      end else if (pick < 45) begin
        case ($urandom_range(0, 9))
          0:       begin wv = $urandom; hv = $urandom; rv = $urandom; end
          1:       rv = 0;
          2:       wv = $urandom_range(4097, 65535);
          3:       hv = 0;
          default: ;
        endcase
        push_word(OP_ADD_MODE, conn, name_ok, wv, hv, rv);
      end else if (pick < 70) begin
        case ($urandom_range(0, 7))
          0:       wv = $urandom;
          1:       hv = hv | (8192 << $urandom_range(0, 2));
          default: ;
        endcase
        push_word(OP_SET_MODE, conn, name_ok, wv, hv, $urandom);
      end else begin
        push_word(OP_READ_CUR, conn, name_ok, $urandom, $urandom, $urandom);
      end
    end

    // Reset is released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (word_backlog.size() != 0 || words_taken != words_issued) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d request words and %0d replies: %0d ok, %0d rejected,",
             words_taken, replies_seen, n_ok, n_bad);
    $display("%0d full or not found; %0d connectors claimed.", n_full, n_claims);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
